// File: rtl/core/id_string_pair_lexer_unit_assert.svh
// Assertion macros for the id/string pair lexer.
// Used by the top level; depends on i_clk and i_rst_n being in scope.
`ifndef ID_STRING_PAIR_LEXER_UNIT_ASSERT_SVH
`define ID_STRING_PAIR_LEXER_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Check a condition at every clock edge outside reset
`define IDSP_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("idsp assertion failed");

// Check that an antecedent implies a consequent in the same cycle
`define IDSP_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("idsp assertion failed");

// Check that an antecedent implies a consequent in the next cycle
`define IDSP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("idsp assertion failed");

`else

`define IDSP_ASSERT_ALWAYS(lbl, cond)
`define IDSP_ASSERT_IMPLY(lbl, ante, cons)
`define IDSP_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// File: rtl/core/idsp_pkg.sv
// Shared types and constants of the id/string pair lexer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package idsp_pkg;

    // Line counter width default and fixed width of the line field
    localparam int LINE_BITS_DEF = 24;
    localparam int OUT_LINE_W    = 24;

    // Result queue geometry
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Result kinds
    localparam logic [2:0] KIND_ID   = 3'd0;
    localparam logic [2:0] KIND_TEXT = 3'd1;
    localparam logic [2:0] KIND_PAIR = 3'd2;
    localparam logic [2:0] KIND_OK   = 3'd3;
    localparam logic [2:0] KIND_ERR  = 3'd4;

    // Error codes
    localparam logic [1:0] ERR_OPEN_COMMENT = 2'd0;
    localparam logic [1:0] ERR_UNEXPECTED   = 2'd1;
    localparam logic [1:0] ERR_NO_STRING    = 2'd2;
    localparam logic [1:0] ERR_OPEN_STRING  = 2'd3;

    // Input word
    typedef struct packed {
        logic [7:0] byte_in;
        logic       final_byte;
    } t_in_word;

    // Result word
    typedef struct packed {
        logic [2:0]            kind;
        logic [7:0]            byte_out;
        logic [1:0]            error_code;
        logic [OUT_LINE_W-1:0] line_number;
        logic                  run_last;
    } t_out_word;

    // Up to two results produced by one lexer step
    typedef struct packed {
        logic [1:0] count;
        t_out_word  res0;
        t_out_word  res1;
    } t_lex_res;

endpackage

// File: rtl/core/id_string_pair_lexer_unit.sv
// Top level of the id/string pair lexer: input register, lexer, result queue.
// Depends on idsp_pkg, idsp_lex_core, idsp_res_queue and the assertion header.
//
//  channel   direction  handshake                  word
//  input     in         i_in_valid / o_in_ready    i_in_word  (t_in_word)
//  result    out        o_out_valid / i_out_ready  o_out_word (t_out_word)
//
// One byte per cycle while the queue has room: a byte is held in the input
// register, lexed combinationally and written into a four-word result queue,
// where its results are offered to the consumer in order. A byte yields
// zero, one or two results; the single queue read port delivers one result
// per cycle while i_out_ready is high, which sets the sustained rate when
// most bytes produce results. Input stalls only while the queue lacks room
// for two words. Reset is synchronous and empties both sides.
`timescale 1ns / 1ps

module id_string_pair_lexer_unit #(
    parameter int LINE_BITS = idsp_pkg::LINE_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  idsp_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output idsp_pkg::t_out_word o_out_word
);
    import idsp_pkg::*;

    `include "id_string_pair_lexer_unit_assert.svh"

    logic              r_in_valid;
    t_in_word          r_in_word;
    logic              step;
    t_lex_res          lex_res;
    logic [QCNT_W-1:0] queue_count;
    logic              out_verdict;

    // Lex the held byte when the queue has room for two words
    assign step       = r_in_valid && (queue_count <= QCNT_W'(QUEUE_DEPTH - 2));
    assign o_in_ready = !r_in_valid || step;

    // Hold the incoming byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_word <= i_in_word;
        end
    end

    idsp_lex_core #(
        .LINE_BITS(LINE_BITS)
    ) u_lex (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_word  (r_in_word),
        .o_res   (lex_res)
    );

    idsp_res_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  ((step ? lex_res : '0)),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_word  (o_out_word),
        .o_count (queue_count)
    );

    // Flag a verdict word on the output
    assign out_verdict = o_out_valid &&
                         (o_out_word.kind == KIND_OK || o_out_word.kind == KIND_ERR);

    // Queue never holds more words than it has entries
    `IDSP_ASSERT_ALWAYS(a_queue_bound, queue_count <= QCNT_W'(QUEUE_DEPTH))
    // A verdict always closes the results of its byte
    `IDSP_ASSERT_IMPLY(a_verdict_last, out_verdict, o_out_word.run_last)
    // A stalled byte stays in the input register
    `IDSP_ASSERT_NEXT(a_in_hold, r_in_valid && !step, r_in_valid && $stable(r_in_word))

endmodule

// File: rtl/core/idsp_lex_core.sv
// Lexer state machine: state, line counter and held error, one byte per step.
// Depends on idsp_pkg for word types, kinds and error codes.
`timescale 1ns / 1ps

module idsp_lex_core #(
    parameter int LINE_BITS = idsp_pkg::LINE_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  idsp_pkg::t_in_word  i_word,
    output idsp_pkg::t_lex_res  o_res
);
    import idsp_pkg::*;

    typedef enum logic [3:0] {
        S_NORMAL,
        S_SLASH,
        S_LINE,
        S_BLOCK,
        S_BSTAR,
        S_ID,
        S_GAP,
        S_TEXT,
        S_ERR
    } t_lex_state;

    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_USCORE = 8'h5F;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;

    localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};
    localparam logic [LINE_BITS-1:0] LINE_ONE = LINE_BITS'(1);

    t_lex_state           r_state, mid_state, n_state;
    logic [LINE_BITS-1:0] r_line, mid_line, n_line, line_inc;
    logic [1:0]           r_held_code, n_held_code;
    logic [LINE_BITS-1:0] r_held_line, n_held_line;
    logic [7:0]           r_held_byte, n_held_byte;

    logic       is_id, is_blank, fin;
    logic [7:0] c;
    logic       emit_step;
    t_out_word  step_word, verdict_word;

    // Classify the current byte
    assign c        = i_word.byte_in;
    assign fin      = i_word.final_byte;
    assign is_blank = c inside {CH_SPACE, CH_TAB, CH_CR};
    assign is_id    = c inside {[8'h41:8'h5A], [8'h61:8'h7A], [8'h30:8'h39],
                                CH_USCORE, CH_DASH};
    assign line_inc = (r_line == LINE_MAX) ? r_line : LINE_BITS'(r_line + LINE_ONE);

    // Advance the lexer by one byte and form its results
    always_comb begin
        mid_state   = r_state;
        mid_line    = r_line;
        n_held_code = r_held_code;
        n_held_line = r_held_line;
        n_held_byte = r_held_byte;
        emit_step   = 1'b0;
        step_word   = '0;

        case (r_state)
            S_NORMAL: begin
                if (c == CH_NL) begin
                    mid_line = line_inc;
                end else if (is_blank) begin
                    mid_state = S_NORMAL;
                end else if (c == CH_SLASH) begin
                    mid_state = S_SLASH;
                end else if (is_id) begin
                    emit_step          = 1'b1;
                    step_word.kind     = KIND_ID;
                    step_word.byte_out = c;
                    mid_state          = S_ID;
                end else begin
                    mid_state   = S_ERR;
                    n_held_code = ERR_UNEXPECTED;
                    n_held_line = r_line;
                    n_held_byte = c;
                end
            end
            S_SLASH: begin
                if (c == CH_SLASH) begin
                    mid_state = S_LINE;
                end else if (c == CH_STAR) begin
                    mid_state = S_BLOCK;
                end else begin
                    mid_state   = S_ERR;
                    n_held_code = ERR_UNEXPECTED;
                    n_held_line = r_line;
                    n_held_byte = CH_SLASH;
                end
            end
            S_LINE: begin
                if (c == CH_NL) begin
                    mid_line  = line_inc;
                    mid_state = S_NORMAL;
                end
            end
            S_BLOCK, S_BSTAR: begin
                if (r_state == S_BSTAR && c == CH_SLASH) begin
                    mid_state = S_NORMAL;
                end else begin
                    // a newline on the final byte is not counted here
                    if (c == CH_NL && !fin) begin
                        mid_line = line_inc;
                    end
                    mid_state = (c == CH_STAR) ? S_BSTAR : S_BLOCK;
                end
            end
            S_ID: begin
                if (is_id) begin
                    emit_step          = 1'b1;
                    step_word.kind     = KIND_ID;
                    step_word.byte_out = c;
                end else if (is_blank) begin
                    mid_state = S_GAP;
                end else if (c == CH_QUOTE) begin
                    mid_state = S_TEXT;
                end else begin
                    mid_state   = S_ERR;
                    n_held_code = ERR_NO_STRING;
                    n_held_line = r_line;
                    n_held_byte = c;
                end
            end
            S_GAP: begin
                if (c == CH_QUOTE) begin
                    mid_state = S_TEXT;
                end else if (!is_blank) begin
                    mid_state   = S_ERR;
                    n_held_code = ERR_NO_STRING;
                    n_held_line = r_line;
                    n_held_byte = c;
                end
            end
            S_TEXT: begin
                emit_step = 1'b1;
                if (c == CH_QUOTE) begin
                    step_word.kind = KIND_PAIR;
                    mid_state      = S_NORMAL;
                end else begin
                    if (c == CH_NL) begin
                        mid_line = line_inc;
                    end
                    step_word.kind     = KIND_TEXT;
                    step_word.byte_out = c;
                end
            end
            default: begin
                mid_state = r_state;
            end
        endcase

        step_word.line_number = OUT_LINE_W'(mid_line);
        step_word.run_last    = !fin;

        // Verdict on the final byte
        verdict_word             = '0;
        verdict_word.run_last    = 1'b1;
        verdict_word.line_number = OUT_LINE_W'(mid_line);
        case (mid_state)
            S_NORMAL, S_LINE: begin
                verdict_word.kind = KIND_OK;
            end
            S_SLASH: begin
                verdict_word.kind       = KIND_ERR;
                verdict_word.byte_out   = CH_SLASH;
                verdict_word.error_code = ERR_UNEXPECTED;
            end
            S_BLOCK, S_BSTAR: begin
                verdict_word.kind       = KIND_ERR;
                verdict_word.byte_out   = c;
                verdict_word.error_code = ERR_OPEN_COMMENT;
            end
            S_ID, S_GAP: begin
                verdict_word.kind       = KIND_ERR;
                verdict_word.byte_out   = c;
                verdict_word.error_code = ERR_NO_STRING;
            end
            S_TEXT: begin
                verdict_word.kind       = KIND_ERR;
                verdict_word.byte_out   = c;
                verdict_word.error_code = ERR_OPEN_STRING;
            end
            default: begin
                verdict_word.kind        = KIND_ERR;
                verdict_word.byte_out    = n_held_byte;
                verdict_word.error_code  = n_held_code;
                verdict_word.line_number = OUT_LINE_W'(n_held_line);
            end
        endcase

        // Return to the start state after the final byte
        n_state = fin ? S_NORMAL : mid_state;
        n_line  = fin ? LINE_ONE : mid_line;

        // Pack the results in order
        o_res.count = 2'(emit_step) + 2'(fin);
        o_res.res0  = emit_step ? step_word : verdict_word;
        o_res.res1  = verdict_word;
    end

    // Hold state, line count and the first error
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_NORMAL;
            r_line      <= LINE_ONE;
            r_held_code <= '0;
            r_held_line <= '0;
            r_held_byte <= '0;
        end else if (i_step) begin
            r_state     <= n_state;
            r_line      <= n_line;
            r_held_code <= n_held_code;
            r_held_line <= n_held_line;
            r_held_byte <= n_held_byte;
        end
    end

endmodule

// File: rtl/core/idsp_res_queue.sv
// Result queue: takes up to two result words per cycle, gives one per cycle while i_ready is high.
// Depends on idsp_pkg for the result word type and queue geometry.
`timescale 1ns / 1ps

module idsp_res_queue (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  idsp_pkg::t_lex_res        i_push,
    output logic                      o_valid,
    input  logic                      i_ready,
    output idsp_pkg::t_out_word       o_word,
    output logic [idsp_pkg::QCNT_W-1:0] o_count
);
    import idsp_pkg::*;

    t_out_word          r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_head, r_tail, n_head, n_tail, tail_next;
    logic [QCNT_W-1:0]  r_count, n_count;
    logic               pop;

    assign o_valid   = (r_count != '0);
    assign o_word    = r_mem[r_head];
    assign o_count   = r_count;
    assign pop       = o_valid && i_ready;
    assign tail_next = QPTR_W'(r_tail + QPTR_W'(1));

    // Advance pointers and count
    always_comb begin
        n_head  = pop ? QPTR_W'(r_head + QPTR_W'(1)) : r_head;
        n_tail  = QPTR_W'(r_tail + QPTR_W'(i_push.count));
        n_count = QCNT_W'(r_count + QCNT_W'(i_push.count) - QCNT_W'(pop));
    end

    // Write incoming words
    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_tail] <= i_push.res0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[tail_next] <= i_push.res1;
        end
    end

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

endmodule
